>>> rtl/eabv_pkg.sv
`default_nettype none

package eabv_pkg;

  localparam int unsigned ANGLE_W = 16;
  localparam int unsigned OUT_W   = 16;

  // pi/2 in Q2.30
  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

  // One entry of the quarter-wave sine table, worked out at elaboration.
  // Taylor series in Q2.30, rounded half up to fb fraction bits, clamped to [0, 1.0].
  function automatic logic [31:0] sine_entry(input int unsigned idx,
                                             input int unsigned tb,
                                             input int unsigned fb);
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint          sum;
    longint          v;
    int unsigned     sh;
    x    = (HALF_PI_Q30 * 64'(idx) + (64'd1 << (tb - 1))) >> tb;
    x2   = (x * x + (64'd1 << 29)) >> 30;
    term = x;
    sum  = longint'(x);
    for (int unsigned k = 1; k <= 15; k++) begin
      term = (term * x2) >> 30;
      // divide by (2k)(2k+1)
      unique case (k)
        1: begin
          term = term / 64'd6;
        end
        2: begin
          term = term / 64'd20;
        end
        3: begin
          term = term / 64'd42;
        end
        4: begin
          term = term / 64'd72;
        end
        5: begin
          term = term / 64'd110;
        end
        6: begin
          term = term / 64'd156;
        end
        7: begin
          term = term / 64'd210;
        end
        8: begin
          term = term / 64'd272;
        end
        9: begin
          term = term / 64'd342;
        end
        10: begin
          term = term / 64'd420;
        end
        11: begin
          term = term / 64'd506;
        end
        12: begin
          term = term / 64'd600;
        end
        13: begin
          term = term / 64'd702;
        end
        14: begin
          term = term / 64'd812;
        end
        default: begin
          // last term of the series
          term = term / 64'd930;
        end
      endcase
      if (k[0]) begin
        sum = sum - longint'(term);
      end else begin
        sum = sum + longint'(term);
      end
    end
    if (sum < 0) begin
      sum = 0;
    end
    sh = 30 - fb;
    if (sh > 0) begin
      v = (sum + (longint'(1) << (sh - 1))) >>> sh;
    end else begin
      v = sum;
    end
    if (v > (longint'(1) << fb)) begin
      v = longint'(1) << fb;
    end
    return v[31:0];
  endfunction

endpackage

`default_nettype wire

>>> rtl/euler_angles_to_basis_vectors_top.sv
// Pipeline: a request accepted at a clock edge passes one table stage and three product stages
//   (B, C, D) and then shows its result on the output ports, with done_o high.
// Throughput: one request per cycle; busy stays low in operation and the receiver cannot stall.
// Reset: rst_ni clears every valid bit at once; busy is high in reset and is cleared at the
//   first clock edge after release, then low for good.
`default_nettype none

module euler_angles_to_basis_vectors_top
  import eabv_pkg::*;
#(
  parameter int TABLE_BITS    = 8,
  parameter int FRACTION_BITS = 14
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       start,
  output logic                            busy,
  input  wire logic [ANGLE_W-1:0]         pitch_angle_i,
  input  wire logic [ANGLE_W-1:0]         yaw_angle_i,
  input  wire logic [ANGLE_W-1:0]         roll_angle_i,
  output logic                            done_o,
  output logic signed [OUT_W-1:0]         forward_x_o,
  output logic signed [OUT_W-1:0]         forward_y_o,
  output logic signed [OUT_W-1:0]         forward_z_o,
  output logic signed [OUT_W-1:0]         right_x_o,
  output logic signed [OUT_W-1:0]         right_y_o,
  output logic signed [OUT_W-1:0]         right_z_o,
  output logic signed [OUT_W-1:0]         up_x_o,
  output logic signed [OUT_W-1:0]         up_y_o,
  output logic signed [OUT_W-1:0]         up_z_o
);

  localparam int VW = FRACTION_BITS + 2;

  // Report a component as the low bits of its two's complement value.
  function automatic logic signed [OUT_W-1:0] to_out(input logic signed [VW-1:0] v);
    logic signed [63:0] e;
    e = 64'(v);
    return e[OUT_W-1:0];
  endfunction

  logic busy_q;
  logic accept;
  logic vld_a_q;

  // Hold busy through reset and drop it at the first clock edge after release.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b1;
      vld_a_q <= 1'b0;
    end else begin
      busy_q  <= 1'b0;
      vld_a_q <= accept;
    end
  end

  assign busy   = busy_q;
  assign accept = start & ~busy_q;

  // Stage A: table lookups for all three angles, loaded on each accepted request.
  logic signed [VW-1:0] sp, cp, sy, cy, sr, cr;

  eabv_trig #(.TABLE_BITS(TABLE_BITS), .FRACTION_BITS(FRACTION_BITS)) u_trig_pitch (
    .clk_i  (clk_i),
    .load_i (accept),
    .angle_i(pitch_angle_i),
    .sin_o  (sp),
    .cos_o  (cp)
  );

  eabv_trig #(.TABLE_BITS(TABLE_BITS), .FRACTION_BITS(FRACTION_BITS)) u_trig_yaw (
    .clk_i  (clk_i),
    .load_i (accept),
    .angle_i(yaw_angle_i),
    .sin_o  (sy),
    .cos_o  (cy)
  );

  eabv_trig #(.TABLE_BITS(TABLE_BITS), .FRACTION_BITS(FRACTION_BITS)) u_trig_roll (
    .clk_i  (clk_i),
    .load_i (accept),
    .angle_i(roll_angle_i),
    .sin_o  (sr),
    .cos_o  (cr)
  );

  // Stages B to D: products, triple products, saturating sums into the output register.
  logic                 res_vld;
  logic signed [VW-1:0] fx, fy, fz, rx, ry, rz, ux, uy, uz;

  eabv_rot #(.FRACTION_BITS(FRACTION_BITS)) u_rot (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .valid_i(vld_a_q),
    .sp_i   (sp),
    .cp_i   (cp),
    .sy_i   (sy),
    .cy_i   (cy),
    .sr_i   (sr),
    .cr_i   (cr),
    .valid_o(res_vld),
    .fx_o   (fx),
    .fy_o   (fy),
    .fz_o   (fz),
    .rx_o   (rx),
    .ry_o   (ry),
    .rz_o   (rz),
    .ux_o   (ux),
    .uy_o   (uy),
    .uz_o   (uz)
  );

  assign done_o      = res_vld;
  assign forward_x_o = to_out(fx);
  assign forward_y_o = to_out(fy);
  assign forward_z_o = to_out(fz);
  assign right_x_o   = to_out(rx);
  assign right_y_o   = to_out(ry);
  assign right_z_o   = to_out(rz);
  assign up_x_o      = to_out(ux);
  assign up_y_o      = to_out(uy);
  assign up_z_o      = to_out(uz);

endmodule

`default_nettype wire

>>> rtl/eabv_trig.sv
`default_nettype none

// Sine and cosine of one binary angle from a quarter-wave table, registered.
module eabv_trig
  import eabv_pkg::*;
#(
  parameter int TABLE_BITS    = 8,
  parameter int FRACTION_BITS = 14
) (
  input  wire logic                            clk_i,
  input  wire logic                            load_i,
  input  wire logic [ANGLE_W-1:0]              angle_i,
  output logic signed [FRACTION_BITS+1:0]      sin_o,
  output logic signed [FRACTION_BITS+1:0]      cos_o
);

  localparam int VW   = FRACTION_BITS + 2;
  localparam int MW   = FRACTION_BITS + 1;
  localparam int IW   = TABLE_BITS + 1;
  localparam int QLEN = 1 << TABLE_BITS;

  logic [MW-1:0] sin_rom [QLEN+1];

  for (genvar g = 0; g <= QLEN; g++) begin : g_rom
    assign sin_rom[g] = MW'(sine_entry(g, TABLE_BITS, FRACTION_BITS));
  end

  logic [1:0]            quad_sin;
  logic [1:0]            quad_cos;
  logic [TABLE_BITS-1:0] fine;
  logic [IW-1:0]         idx_sin;
  logic [IW-1:0]         idx_cos;
  logic [MW-1:0]         mag_sin;
  logic [MW-1:0]         mag_cos;
  logic signed [VW-1:0]  sin_d;
  logic signed [VW-1:0]  cos_d;
  logic signed [VW-1:0]  sin_q;
  logic signed [VW-1:0]  cos_q;

  always_comb begin
    quad_sin = angle_i[ANGLE_W-1 -: 2];
    quad_cos = quad_sin + 2'd1;
    fine     = angle_i[ANGLE_W-3 -: TABLE_BITS];
    // odd quadrants run the table backwards
    idx_sin  = quad_sin[0] ? (IW'(QLEN) - {1'b0, fine}) : {1'b0, fine};
    idx_cos  = quad_cos[0] ? (IW'(QLEN) - {1'b0, fine}) : {1'b0, fine};
    mag_sin  = sin_rom[idx_sin];
    mag_cos  = sin_rom[idx_cos];
    sin_d    = quad_sin[1] ? -$signed({1'b0, mag_sin}) : $signed({1'b0, mag_sin});
    cos_d    = quad_cos[1] ? -$signed({1'b0, mag_cos}) : $signed({1'b0, mag_cos});
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      sin_q <= sin_d;
      cos_q <= cos_d;
    end
  end

  assign sin_o = sin_q;
  assign cos_o = cos_q;

endmodule

`default_nettype wire

>>> rtl/eabv_rot.sv
`default_nettype none

// Three-stage product pipeline: pair products, triple products, saturating sums.
module eabv_rot #(
  parameter int FRACTION_BITS = 14
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           valid_i,
  input  wire logic signed [FRACTION_BITS+1:0] sp_i,
  input  wire logic signed [FRACTION_BITS+1:0] cp_i,
  input  wire logic signed [FRACTION_BITS+1:0] sy_i,
  input  wire logic signed [FRACTION_BITS+1:0] cy_i,
  input  wire logic signed [FRACTION_BITS+1:0] sr_i,
  input  wire logic signed [FRACTION_BITS+1:0] cr_i,
  output logic                                valid_o,
  output logic signed [FRACTION_BITS+1:0]     fx_o,
  output logic signed [FRACTION_BITS+1:0]     fy_o,
  output logic signed [FRACTION_BITS+1:0]     fz_o,
  output logic signed [FRACTION_BITS+1:0]     rx_o,
  output logic signed [FRACTION_BITS+1:0]     ry_o,
  output logic signed [FRACTION_BITS+1:0]     rz_o,
  output logic signed [FRACTION_BITS+1:0]     ux_o,
  output logic signed [FRACTION_BITS+1:0]     uy_o,
  output logic signed [FRACTION_BITS+1:0]     uz_o
);

  localparam int VW = FRACTION_BITS + 2;
  localparam int PW = 2 * VW;
  localparam int SW = VW + 1;

  localparam logic signed [VW-1:0] ONE_V = {2'b01, {FRACTION_BITS{1'b0}}};
  localparam logic signed [PW-1:0] ONE_P = PW'(ONE_V);
  localparam logic signed [PW-1:0] HALF_P = PW'(ONE_V) >>> 1;
  localparam logic signed [SW-1:0] ONE_S = SW'(ONE_V);

  // round half up, floor shift, clamp to +/- 1.0
  function automatic logic signed [VW-1:0] qmul(input logic signed [VW-1:0] a,
                                                input logic signed [VW-1:0] b);
    logic signed [PW-1:0] p;
    logic signed [PW-1:0] s;
    logic signed [VW-1:0] r;
    p = PW'(a) * PW'(b);
    s = (p + HALF_P) >>> FRACTION_BITS;
    if (s > ONE_P) begin
      r = ONE_V;
    end else if (s < -ONE_P) begin
      r = -ONE_V;
    end else begin
      r = s[VW-1:0];
    end
    return r;
  endfunction

  function automatic logic signed [VW-1:0] sat_add(input logic signed [VW-1:0] a,
                                                   input logic signed [VW-1:0] b);
    logic signed [SW-1:0] s;
    logic signed [VW-1:0] r;
    s = {a[VW-1], a} + {b[VW-1], b};
    if (s > ONE_S) begin
      r = ONE_V;
    end else if (s < -ONE_S) begin
      r = -ONE_V;
    end else begin
      r = s[VW-1:0];
    end
    return r;
  endfunction

  // stage B: products of two table values, with -sp and the yaw table values passed along
  logic                 b_vld_q;
  logic signed [VW-1:0] nsrsp_q, crsp_q, b_sy_q, b_cy_q;
  logic signed [VW-1:0] b_fx_q, b_fy_q, b_fz_q, b_rz_q, b_uz_q;
  logic signed [VW-1:0] crsy_q, ncrcy_q, srsy_q, nsrcy_q;

  // stage C: triple products, with the pair products passed along
  logic                 c_vld_q;
  logic signed [VW-1:0] c_fx_q, c_fy_q, c_fz_q, c_rz_q, c_uz_q;
  logic signed [VW-1:0] c_crsy_q, c_ncrcy_q, c_srsy_q, c_nsrcy_q;
  logic signed [VW-1:0] m_rx_q, m_ry_q, m_ux_q, m_uy_q;

  // stage D: sums, with the other components passed along
  logic                 d_vld_q;
  logic signed [VW-1:0] fx_q, fy_q, fz_q, rx_q, ry_q, rz_q, ux_q, uy_q, uz_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_vld_q <= 1'b0;
      c_vld_q <= 1'b0;
      d_vld_q <= 1'b0;
    end else begin
      b_vld_q <= valid_i;
      c_vld_q <= b_vld_q;
      d_vld_q <= c_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    nsrsp_q <= qmul(-sr_i, sp_i);
    crsp_q  <= qmul(cr_i, sp_i);
    b_sy_q  <= sy_i;
    b_cy_q  <= cy_i;
    b_fx_q  <= qmul(cp_i, cy_i);
    b_fy_q  <= qmul(cp_i, sy_i);
    b_fz_q  <= -sp_i;
    b_rz_q  <= qmul(-sr_i, cp_i);
    b_uz_q  <= qmul(cr_i, cp_i);
    crsy_q  <= qmul(-cr_i, -sy_i);
    ncrcy_q <= qmul(-cr_i, cy_i);
    srsy_q  <= qmul(-sr_i, -sy_i);
    nsrcy_q <= qmul(-sr_i, cy_i);

    c_fx_q    <= b_fx_q;
    c_fy_q    <= b_fy_q;
    c_fz_q    <= b_fz_q;
    c_rz_q    <= b_rz_q;
    c_uz_q    <= b_uz_q;
    c_crsy_q  <= crsy_q;
    c_ncrcy_q <= ncrcy_q;
    c_srsy_q  <= srsy_q;
    c_nsrcy_q <= nsrcy_q;
    m_rx_q    <= qmul(nsrsp_q, b_cy_q);
    m_ry_q    <= qmul(nsrsp_q, b_sy_q);
    m_ux_q    <= qmul(crsp_q, b_cy_q);
    m_uy_q    <= qmul(crsp_q, b_sy_q);

    fx_q <= c_fx_q;
    fy_q <= c_fy_q;
    fz_q <= c_fz_q;
    rz_q <= c_rz_q;
    uz_q <= c_uz_q;
    rx_q <= sat_add(m_rx_q, c_crsy_q);
    ry_q <= sat_add(m_ry_q, c_ncrcy_q);
    ux_q <= sat_add(m_ux_q, c_srsy_q);
    uy_q <= sat_add(m_uy_q, c_nsrcy_q);
  end

  assign valid_o = d_vld_q;
  assign fx_o    = fx_q;
  assign fy_o    = fy_q;
  assign fz_o    = fz_q;
  assign rx_o    = rx_q;
  assign ry_o    = ry_q;
  assign rz_o    = rz_q;
  assign ux_o    = ux_q;
  assign uy_o    = uy_q;
  assign uz_o    = uz_q;

endmodule

`default_nettype wire

>>> rtl/eabv_checker.sv
`default_nettype none

module eabv_checker (
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic start,
  input wire logic busy,
  input wire logic done_o
);

  // every accepted request yields a result after the table and product stages
  a_req_to_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##4 done_o)
    else $error("request accepted without a result four cycles later");

  // no result without a matching earlier request
  a_done_from_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start && !busy, 4))
    else $error("result without a matching request");

  // once released, busy never rises again
  a_busy_stays_low: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy |=> !busy)
    else $error("busy rose after reset");

endmodule

bind euler_angles_to_basis_vectors_top eabv_checker u_eabv_checker (
  .clk_i (clk_i),
  .rst_ni(rst_ni),
  .start (start),
  .busy  (busy),
  .done_o(done_o)
);

`default_nettype wire
